// File: hw/rtl/tncull_pkg.sv
// ----------------------------------------------------------------------------
// tncull_pkg
// Shared types and constants for the triangle normal and box cull block.
// ----------------------------------------------------------------------------
package tncull_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_MIN_X = 3'd0;
    localparam logic [2:0] REG_MIN_Y = 3'd1;
    localparam logic [2:0] REG_MIN_Z = 3'd2;
    localparam logic [2:0] REG_MAX_X = 3'd3;
    localparam logic [2:0] REG_MAX_Y = 3'd4;
    localparam logic [2:0] REG_MAX_Z = 3'd5;

    // Normalized magnitude width ahead of the length computation
    localparam int NORM_BITS = 30;

    // One triangle, three Q16.16 vertices
    typedef struct packed {
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] c_x;
        logic signed [31:0] c_y;
        logic signed [31:0] c_z;
    } t_tri_in;

    // Cull flag and Q1.14 unit normal
    typedef struct packed {
        logic               keep;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic               degenerate;
    } t_tri_out;

    // Per-beat flags that ride along the pipeline
    typedef struct packed {
        logic       keep;
        logic       degen;
        logic [2:0] neg;
    } t_hdr;

endpackage

// File: hw/rtl/triangle_normal_and_box_cull.sv
// ----------------------------------------------------------------------------
// triangle_normal_and_box_cull
// Face normal of a triangle as a Q1.14 unit vector, plus box cull flag.
// ----------------------------------------------------------------------------
// Takes one triangle per clock and returns one result per clock while the
// output is not held. The pipeline has eight stages for edges, products,
// cross terms, magnitude, bit length, normalizing shift, squares and their
// sum, 31 stages of the digit-by-digit square root for the vector length,
// one stage that forms the rounded numerators, NORMAL_FRAC_BITS + 1 stages of
// the restoring divider that forms the three components, and the output
// register. All stages advance together; the pipeline holds while a result
// waits at the output and i_out_ready is low. A zero cross product gives a zero
// normal with the degenerate flag set. The user must write the box registers
// only while the block is idle; the block itself does not enforce this.
module triangle_normal_and_box_cull
    import tncull_pkg::*;
#(
    parameter int COORD_BITS       = 32,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_tri_in          i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_tri_out         o_out_data,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [31:0]      i_cfg_data
);

    localparam int EW    = COORD_BITS + 1;          // edge width
    localparam int PW    = 2 * EW;                  // product width
    localparam int CW    = PW + 1;                  // cross term width
    localparam int BLW   = $clog2(CW + 1);
    localparam int SQW   = 2 * NORM_BITS;
    localparam int SUMW  = SQW + 2;
    localparam int SQ_N  = NORM_BITS + 1;           // root bits / stages
    localparam int RTW   = SUMW + 1;
    localparam int LENW  = SQ_N;
    localparam int F     = NORMAL_FRAC_BITS;
    localparam int NUMW  = NORM_BITS + F + 1;
    localparam int QW    = F + 1;
    localparam int DN    = F + 1;
    localparam int QXW   = (QW > 17) ? QW : 17;

    // global advance
    logic w_en;
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    // box registers
    logic signed [31:0] r_box [0:5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box[REG_MIN_X] <= 32'sh8000_0000;
            r_box[REG_MIN_Y] <= 32'sh8000_0000;
            r_box[REG_MIN_Z] <= 32'sh8000_0000;
            r_box[REG_MAX_X] <= 32'sh7FFF_FFFF;
            r_box[REG_MAX_Y] <= 32'sh7FFF_FFFF;
            r_box[REG_MAX_Z] <= 32'sh7FFF_FFFF;
        end else if (i_cfg_we && (i_cfg_idx <= REG_MAX_Z)) begin
            r_box[i_cfg_idx] <= i_cfg_data;
        end
    end

    // stage 1: coordinates, edges, box test
    logic signed [COORD_BITS-1:0] w_v [0:2][0:2];
    logic signed [EW-1:0]         n_e1 [0:2];
    logic signed [EW-1:0]         n_e2 [0:2];
    logic                         n_keep;
    logic [2:0]                   w_in;

    always_comb begin
        w_v[0][0] = $signed(i_in_data.a_x[COORD_BITS-1:0]);
        w_v[0][1] = $signed(i_in_data.a_y[COORD_BITS-1:0]);
        w_v[0][2] = $signed(i_in_data.a_z[COORD_BITS-1:0]);
        w_v[1][0] = $signed(i_in_data.b_x[COORD_BITS-1:0]);
        w_v[1][1] = $signed(i_in_data.b_y[COORD_BITS-1:0]);
        w_v[1][2] = $signed(i_in_data.b_z[COORD_BITS-1:0]);
        w_v[2][0] = $signed(i_in_data.c_x[COORD_BITS-1:0]);
        w_v[2][1] = $signed(i_in_data.c_y[COORD_BITS-1:0]);
        w_v[2][2] = $signed(i_in_data.c_z[COORD_BITS-1:0]);
        for (int i = 0; i < 3; i++) begin
            w_in[i] = 1'b1;
            for (int j = 0; j < 3; j++) begin
                if (32'(w_v[i][j]) < r_box[j] || 32'(w_v[i][j]) > r_box[j + 3])
                    w_in[i] = 1'b0;
            end
        end
        n_keep = |w_in;
        for (int j = 0; j < 3; j++) begin
            n_e1[j] = EW'(w_v[1][j]) - EW'(w_v[0][j]);
            n_e2[j] = EW'(w_v[2][j]) - EW'(w_v[0][j]);
        end
    end

    logic                 r1_vld, r1_keep;
    logic signed [EW-1:0] r1_e1 [0:2];
    logic signed [EW-1:0] r1_e2 [0:2];

    // stage 2: six products
    logic                 r2_vld, r2_keep;
    logic signed [PW-1:0] r2_p [0:5];

    // stage 3: cross terms
    logic                 r3_vld, r3_keep;
    logic signed [CW-1:0] r3_c [0:2];

    // stage 4: sign and magnitude
    logic                 r4_vld, r4_keep;
    logic [2:0]           r4_neg;
    logic [CW-1:0]        r4_mag [0:2];

    // stage 5: bit length of the largest magnitude
    logic                 r5_vld, r5_keep;
    logic [2:0]           r5_neg;
    logic [CW-1:0]        r5_mag [0:2];
    logic [BLW-1:0]       r5_bl;
    logic [BLW-1:0]       n_bl;
    logic [CW-1:0]        w_or;

    always_comb begin
        w_or = r4_mag[0] | r4_mag[1] | r4_mag[2];
        n_bl = '0;
        for (int i = 0; i < CW; i++) begin
            if (w_or[i])
                n_bl = BLW'(i + 1);
        end
    end

    // stage 6: common normalizing shift
    logic                     r6_vld;
    t_hdr                     r6_hdr;
    logic [NORM_BITS-1:0]     r6_m [0:2];
    logic [CW+NORM_BITS-1:0]  w_sh [0:2];

    always_comb begin
        for (int i = 0; i < 3; i++)
            w_sh[i] = {r5_mag[i], NORM_BITS'(0)} >> r5_bl;
    end

    // stage 7: squares
    logic                 r7_vld;
    t_hdr                 r7_hdr;
    logic [NORM_BITS-1:0] r7_m [0:2];
    logic [SQW-1:0]       r7_sq [0:2];

    // stage 8: sum of squares
    logic                 r8_vld;
    t_hdr                 r8_hdr;
    logic [NORM_BITS-1:0] r8_m [0:2];
    logic [SUMW-1:0]      r8_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
            r8_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_in_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
            r7_vld <= r6_vld;
            r8_vld <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_keep <= n_keep;
            r1_e1   <= n_e1;
            r1_e2   <= n_e2;

            r2_keep <= r1_keep;
            r2_p[0] <= PW'(r1_e1[1]) * PW'(r1_e2[2]);
            r2_p[1] <= PW'(r1_e1[2]) * PW'(r1_e2[1]);
            r2_p[2] <= PW'(r1_e1[2]) * PW'(r1_e2[0]);
            r2_p[3] <= PW'(r1_e1[0]) * PW'(r1_e2[2]);
            r2_p[4] <= PW'(r1_e1[0]) * PW'(r1_e2[1]);
            r2_p[5] <= PW'(r1_e1[1]) * PW'(r1_e2[0]);

            r3_keep <= r2_keep;
            for (int i = 0; i < 3; i++)
                r3_c[i] <= CW'(r2_p[2*i]) - CW'(r2_p[2*i + 1]);

            r4_keep <= r3_keep;
            for (int i = 0; i < 3; i++) begin
                r4_neg[i] <= r3_c[i][CW-1];
                r4_mag[i] <= r3_c[i][CW-1] ? CW'(-r3_c[i]) : CW'(r3_c[i]);
            end

            r5_keep <= r4_keep;
            r5_neg  <= r4_neg;
            r5_mag  <= r4_mag;
            r5_bl   <= n_bl;

            r6_hdr.keep  <= r5_keep;
            r6_hdr.neg   <= r5_neg;
            r6_hdr.degen <= (r5_bl == '0);
            for (int i = 0; i < 3; i++)
                r6_m[i] <= w_sh[i][NORM_BITS-1:0];

            r7_hdr <= r6_hdr;
            r7_m   <= r6_m;
            for (int i = 0; i < 3; i++)
                r7_sq[i] <= SQW'(r6_m[i]) * SQW'(r6_m[i]);

            r8_hdr <= r7_hdr;
            r8_m   <= r7_m;
            r8_sum <= SUMW'(r7_sq[0]) + SUMW'(r7_sq[1]) + SUMW'(r7_sq[2]);
        end
    end

    // square root, one result bit per stage
    logic                 r_sq_vld [0:SQ_N-1];
    t_hdr                 r_sq_hdr [0:SQ_N-1];
    logic [NORM_BITS-1:0] r_sq_m   [0:SQ_N-1][0:2];
    logic [RTW-1:0]       r_sq_v   [0:SQ_N-1];
    logic [RTW-1:0]       r_sq_r   [0:SQ_N-1];
    logic [RTW-1:0]       n_sq_v   [0:SQ_N-1];
    logic [RTW-1:0]       n_sq_r   [0:SQ_N-1];
    logic [RTW-1:0]       w_sq_vi, w_sq_ri, w_sq_t, w_sq_b;

    always_comb begin
        for (int j = 0; j < SQ_N; j++) begin
            w_sq_vi = (j == 0) ? RTW'(r8_sum) : r_sq_v[(j == 0) ? 0 : j - 1];
            w_sq_ri = (j == 0) ? '0 : r_sq_r[(j == 0) ? 0 : j - 1];
            w_sq_b  = RTW'(1) << (2 * (SQ_N - 1 - j));
            w_sq_t  = w_sq_ri + w_sq_b;
            if (w_sq_vi >= w_sq_t) begin
                n_sq_v[j] = w_sq_vi - w_sq_t;
                n_sq_r[j] = (w_sq_ri >> 1) + w_sq_b;
            end else begin
                n_sq_v[j] = w_sq_vi;
                n_sq_r[j] = w_sq_ri >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < SQ_N; j++)
                r_sq_vld[j] <= 1'b0;
        end else if (w_en) begin
            r_sq_vld[0] <= r8_vld;
            for (int j = 1; j < SQ_N; j++)
                r_sq_vld[j] <= r_sq_vld[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_hdr[0] <= r8_hdr;
            r_sq_m[0]   <= r8_m;
            for (int j = 1; j < SQ_N; j++) begin
                r_sq_hdr[j] <= r_sq_hdr[j-1];
                r_sq_m[j]   <= r_sq_m[j-1];
            end
            r_sq_v <= n_sq_v;
            r_sq_r <= n_sq_r;
        end
    end

    // numerators with rounding term
    logic                 r10_vld;
    t_hdr                 r10_hdr;
    logic [LENW-1:0]      r10_len;
    logic [NUMW-1:0]      r10_num [0:2];
    logic [LENW-1:0]      w_len;

    assign w_len = r_sq_r[SQ_N-1][LENW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_vld <= 1'b0;
        end else if (w_en) begin
            r10_vld <= r_sq_vld[SQ_N-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r10_hdr <= r_sq_hdr[SQ_N-1];
            r10_len <= w_len;
            for (int i = 0; i < 3; i++)
                r10_num[i] <= {r_sq_m[SQ_N-1][i], F'(0)} + NUMW'(w_len >> 1);
        end
    end

    // restoring divide, one quotient bit per stage, three lanes
    logic                 r_dv_vld [0:DN-1];
    t_hdr                 r_dv_hdr [0:DN-1];
    logic [LENW-1:0]      r_dv_len [0:DN-1];
    logic [NUMW-1:0]      r_dv_num [0:DN-1][0:2];
    logic [LENW-1:0]      r_dv_rem [0:DN-1][0:2];
    logic [QW-1:0]        r_dv_q   [0:DN-1][0:2];
    logic [LENW-1:0]      n_dv_rem [0:DN-1][0:2];
    logic [QW-1:0]        n_dv_q   [0:DN-1][0:2];
    logic [LENW-1:0]      w_dv_ri, w_dv_l;
    logic [NUMW-1:0]      w_dv_n;
    logic [QW-1:0]        w_dv_qi;
    logic [LENW:0]        w_dv_t;

    always_comb begin
        for (int d = 0; d < DN; d++) begin
            for (int i = 0; i < 3; i++) begin
                if (d == 0) begin
                    w_dv_n  = r10_num[i];
                    w_dv_l  = r10_len;
                    w_dv_ri = LENW'(r10_num[i] >> QW);
                    w_dv_qi = '0;
                end else begin
                    w_dv_n  = r_dv_num[(d == 0) ? 0 : d - 1][i];
                    w_dv_l  = r_dv_len[(d == 0) ? 0 : d - 1];
                    w_dv_ri = r_dv_rem[(d == 0) ? 0 : d - 1][i];
                    w_dv_qi = r_dv_q[(d == 0) ? 0 : d - 1][i];
                end
                w_dv_t = {w_dv_ri, w_dv_n[F - d]};
                n_dv_q[d][i] = w_dv_qi;
                if (w_dv_t >= {1'b0, w_dv_l}) begin
                    n_dv_rem[d][i]   = LENW'(w_dv_t - {1'b0, w_dv_l});
                    n_dv_q[d][i][F-d] = 1'b1;
                end else begin
                    n_dv_rem[d][i] = LENW'(w_dv_t);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < DN; d++)
                r_dv_vld[d] <= 1'b0;
        end else if (w_en) begin
            r_dv_vld[0] <= r10_vld;
            for (int d = 1; d < DN; d++)
                r_dv_vld[d] <= r_dv_vld[d-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_hdr[0] <= r10_hdr;
            r_dv_len[0] <= r10_len;
            r_dv_num[0] <= r10_num;
            for (int d = 1; d < DN; d++) begin
                r_dv_hdr[d] <= r_dv_hdr[d-1];
                r_dv_len[d] <= r_dv_len[d-1];
                r_dv_num[d] <= r_dv_num[d-1];
            end
            r_dv_rem <= n_dv_rem;
            r_dv_q   <= n_dv_q;
        end
    end

    // output: saturate, apply sign, degenerate override
    t_hdr               w_oh;
    logic [QXW-1:0]     w_qx;
    logic signed [15:0] w_n [0:2];
    t_tri_out           n_out;
    t_tri_out           r_out;
    logic               r_out_vld;

    always_comb begin
        w_oh = r_dv_hdr[DN-1];
        for (int i = 0; i < 3; i++) begin
            w_qx = QXW'(r_dv_q[DN-1][i]);
            if (w_oh.degen) begin
                w_n[i] = '0;
            end else if (w_oh.neg[i]) begin
                w_n[i] = (w_qx > QXW'(32768)) ? 16'sh8000 : -$signed(w_qx[15:0]);
            end else begin
                w_n[i] = (w_qx > QXW'(32767)) ? 16'sh7FFF : $signed(w_qx[15:0]);
            end
        end
        n_out.keep       = w_oh.keep;
        n_out.normal_x   = w_n[0];
        n_out.normal_y   = w_n[1];
        n_out.normal_z   = w_n[2];
        n_out.degenerate = w_oh.degen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_dv_vld[DN-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the triangle normal and box cull block.
// ----------------------------------------------------------------------------
// Triangles are queued by an initial block and driven by a clocked driver with
// random gaps. A bit-exact predictor forms the cross product, normalizes it to
// a Q1.14 unit vector and evaluates the box test; the monitor compares every
// result beat with the oldest prediction. Box registers change between phases
// only, once the pipeline has drained.
// ----------------------------------------------------------------------------
module tb
    import tncull_pkg::*;
();

    localparam int FRAC      = 14;
    localparam int LATENCY   = 42 + FRAC;
    localparam int WDOG_MAX  = 20000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    t_tri_in    in_data;
    logic       out_valid;
    logic       out_ready;
    t_tri_out   out_data;
    logic       cfg_we;
    logic [2:0] cfg_idx;
    logic [31:0] cfg_data;

    triangle_normal_and_box_cull dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // Testbench copy of the box bounds
    logic signed [31:0] box_lo [3];
    logic signed [31:0] box_hi [3];

    t_tri_in  tri_pending [$];
    t_tri_out normal_expected [$];
    int       mismatches;
    int       results_seen;
    int       tris_sent;
    int       wdog;
    bit       quiet_tail;
    bit       hold_sender;
    int       in_gap;
    int       out_gap;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic bit vtx_in_box(logic signed [31:0] x, logic signed [31:0] y,
                                      logic signed [31:0] z);
        return x >= box_lo[0] && x <= box_hi[0] && y >= box_lo[1] && y <= box_hi[1]
            && z >= box_lo[2] && z <= box_hi[2];
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic t_tri_out face_normal(t_tri_in t);
        t_tri_out o;
        logic signed [33:0]  e1 [3];
        logic signed [33:0]  e2 [3];
        logic signed [69:0]  cr [3];
        logic [69:0]         mag [3];
        logic [63:0]         m [3];
        logic [63:0]         len;
        logic [63:0]         q;
        int                  blen;
        int                  b;
        e1[0] = 34'(t.b_x) - 34'(t.a_x);
        e1[1] = 34'(t.b_y) - 34'(t.a_y);
        e1[2] = 34'(t.b_z) - 34'(t.a_z);
        e2[0] = 34'(t.c_x) - 34'(t.a_x);
        e2[1] = 34'(t.c_y) - 34'(t.a_y);
        e2[2] = 34'(t.c_z) - 34'(t.a_z);
        cr[0] = 70'(e1[1]) * 70'(e2[2]) - 70'(e1[2]) * 70'(e2[1]);
        cr[1] = 70'(e1[2]) * 70'(e2[0]) - 70'(e1[0]) * 70'(e2[2]);
        cr[2] = 70'(e1[0]) * 70'(e2[1]) - 70'(e1[1]) * 70'(e2[0]);
        o = '0;
        o.keep = vtx_in_box(t.a_x, t.a_y, t.a_z) || vtx_in_box(t.b_x, t.b_y, t.b_z)
              || vtx_in_box(t.c_x, t.c_y, t.c_z);
        blen = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = cr[i] < 0 ? 70'(-cr[i]) : 70'(cr[i]);
            b = 0;
            for (int k = 0; k < 70; k++) if (mag[i][k]) b = k + 1;
            if (b > blen) blen = b;
        end
        if (blen == 0) begin
            o.degenerate = 1'b1;
            return o;
        end
        for (int i = 0; i < 3; i++)
            m[i] = blen > NORM_BITS ? 64'(mag[i] >> (blen - NORM_BITS))
                                    : 64'(mag[i] << (NORM_BITS - blen));
        len = root_floor(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int i = 0; i < 3; i++) begin
            logic signed [31:0] n;
            q = ((m[i] << FRAC) + (len >> 1)) / len;
            if (q > 32768) q = 32768;
            n = cr[i] < 0 ? -32'(q) : 32'(q);
            if (n > 32767) n = 32767;
            case (i)
                0: o.normal_x = n[15:0];
                1: o.normal_y = n[15:0];
                default: o.normal_z = n[15:0];
            endcase
        end
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: takes triangles from the pending queue, random gaps
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_gap   <= 0;
        end else begin
            logic fire;
            fire = in_valid && in_ready;
            if (fire) begin
                normal_expected.insert(normal_expected.size(), face_normal(in_data));
                tris_sent <= tris_sent + 1;
            end
            if (in_valid && !fire) begin
                // hold beat
            end else if (in_gap > 0) begin
                in_valid <= 1'b0;
                in_gap   <= in_gap - 1;
            end else if (!hold_sender && tri_pending.size() > 0) begin
                if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                    in_valid <= 1'b0;
                    in_gap   <= $urandom_range(1, 18);
                end else begin
                    in_valid <= 1'b1;
                    in_data  <= tri_pending.pop_front();
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: random back-pressure, compares against oldest prediction
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch #%0d on %s: got %0d expected %0d (result %0d)",
                 mismatches, what, got, want, results_seen);
        mismatches++;
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            out_gap   <= 0;
        end else begin
            if (out_valid && out_ready) begin
                if (normal_expected.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end else begin
                    t_tri_out w;
                    w = normal_expected.pop_front();
                    if (out_data.keep !== w.keep)
                        report_mismatch("keep", out_data.keep, w.keep);
                    if (out_data.normal_x !== w.normal_x)
                        report_mismatch("normal_x", out_data.normal_x, w.normal_x);
                    if (out_data.normal_y !== w.normal_y)
                        report_mismatch("normal_y", out_data.normal_y, w.normal_y);
                    if (out_data.normal_z !== w.normal_z)
                        report_mismatch("normal_z", out_data.normal_z, w.normal_z);
                    if (out_data.degenerate !== w.degenerate)
                        report_mismatch("degenerate", out_data.degenerate, w.degenerate);
                end
                results_seen <= results_seen + 1;
            end
            if (out_gap > 0) begin
                out_ready <= 1'b0;
                out_gap   <= out_gap - 1;
            end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
                out_ready <= 1'b0;
                out_gap   <= $urandom_range(1, 18);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no beat on either side
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            wdog <= 0;
        end else begin
            wdog <= wdog + 1;
            if (wdog >= WDOG_MAX) begin
                $display("watchdog expired");
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic add_tri(t_tri_in t);
        tri_pending.insert(tri_pending.size(), t);
    endtask

    task automatic write_box(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        if (idx <= REG_MIN_Z) box_lo[idx] = val;
        else if (idx <= REG_MAX_Z) box_hi[idx - REG_MAX_X] = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_box(logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
                           logic [31:0] hx, logic [31:0] hy, logic [31:0] hz);
        write_box(REG_MIN_X, lx);
        write_box(REG_MIN_Y, ly);
        write_box(REG_MIN_Z, lz);
        write_box(REG_MAX_X, hx);
        write_box(REG_MAX_Y, hy);
        write_box(REG_MAX_Z, hz);
    endtask

    task automatic drain;
        while (tri_pending.size() > 0 || normal_expected.size() > 0 || in_valid)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 64)) - 32);
        endcase
    endfunction

    function automatic t_tri_in rand_tri();
        t_tri_in t;
        int mode;
        mode = $urandom_range(0, 9);
        mode = mode < 4 ? 0 : mode < 7 ? 1 : mode < 8 ? 2 : 3;
        t = {rand_coord(mode), rand_coord(mode), rand_coord(mode),
             rand_coord(mode), rand_coord(mode), rand_coord(mode),
             rand_coord(mode), rand_coord(mode), rand_coord(mode)};
        // some repeated vertices to hit a zero cross product, or a shared x coordinate
        case ($urandom_range(0, 11))
            0: t.c_x = t.a_x;
            1: begin
                t.b_x = t.a_x; t.b_y = t.a_y; t.b_z = t.a_z;
            end
            2: begin
                t.c_x = t.b_x; t.c_y = t.b_y; t.c_z = t.b_z;
            end
            default: ;
        endcase
        return t;
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) add_tri(rand_tri());
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_tri_in t;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_idx     = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_ready   = 1'b0;
        mismatches  = 0;
        results_seen = 0;
        tris_sent   = 0;
        wdog        = 0;
        quiet_tail  = 1'b0;
        hold_sender = 1'b0;
        in_gap      = 0;
        out_gap     = 0;
        for (int i = 0; i < 3; i++) begin
            box_lo[i] = 32'h80000000;
            box_hi[i] = 32'h7fffffff;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: unit triangles, extremes, degenerate cases
        add_tri({32'sd0, 32'sd0, 32'sd0, 32'sh10000, 32'sd0, 32'sd0,
                 32'sd0, 32'sh10000, 32'sd0});
        add_tri({32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sh10000, 32'sd0,
                 32'sh10000, 32'sd0, 32'sd0});
        add_tri({32'sd5, 32'sd5, 32'sd5, 32'sd5, 32'sd5, 32'sd5,
                 32'sd5, 32'sd5, 32'sd5});
        add_tri({32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd1, 32'sd1,
                 32'sd2, 32'sd2, 32'sd2});
        add_tri({32'h80000000, 32'h80000000, 32'h80000000,
                 32'h7fffffff, 32'h80000000, 32'h80000000,
                 32'h80000000, 32'h7fffffff, 32'h7fffffff});
        add_tri({32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                 32'h80000000, 32'h7fffffff, 32'h80000000,
                 32'h7fffffff, 32'h80000000, 32'h80000000});
        add_tri({32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd0, 32'sd0,
                 32'sd0, 32'sd1, 32'sd0});
        add_tri({32'hffffffff, 32'sd0, 32'sd3, 32'sd1, 32'sd2, 32'sd0,
                 32'sd0, 32'hffffffff, 32'sd7});
        add_tri({32'sh10000, 32'sh10000, 32'sh10000, 32'sh20000, 32'sh10000,
                 32'sh10000, 32'sh10000, 32'sh10000, 32'sh20000});
        for (int i = 0; i < 6; i++) add_tri(rand_tri());
        drain();

        // Inclusive box around the origin: vertices on bounds and just outside
        set_box(32'hffff0000, 32'hffff0000, 32'hffff0000,
                32'h00010000, 32'h00010000, 32'h00010000);
        add_tri({32'h00010000, 32'hffff0000, 32'sd0, 32'h00010001, 32'sd0,
                 32'sd0, 32'sd0, 32'h00020000, 32'sd0});
        add_tri({32'h00010001, 32'sd0, 32'sd0, 32'sd0, 32'hfffeffff,
                 32'sd0, 32'sd0, 32'sd0, 32'h00010001});
        add_tri({32'sd9, 32'sd9, 32'sd9, 32'sd9, 32'sd0, 32'sd0,
                 32'sd0, 32'sd0, 32'sd9});
        for (int i = 0; i < 60; i++) begin
            t = rand_tri();
            if ($urandom_range(0, 1)) t.a_x = 32'($signed($urandom_range(0, 262144)) - 131072);
            add_tri(t);
        end
        // let part of the batch go, then pause the sender until the pipeline
        // has emptied
        while (tri_pending.size() > 30) @(posedge clk);
        hold_sender = 1'b1;
        while (normal_expected.size() > 0 || in_valid) @(posedge clk);
        hold_sender = 1'b0;
        random_phase(100);

        // Empty box: nothing is ever kept
        set_box(32'sd100, 32'h80000000, 32'h80000000, 32'sd99, 32'h7fffffff, 32'h7fffffff);
        random_phase(60);

        // Random box, plus an ignored write to an out-of-range index
        set_box($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= 3'd7;
        cfg_data <= 32'h0;
        @(posedge clk);
        cfg_we   <= 1'b0;
        random_phase(80);

        // Small box near origin, then a tail with no idling
        set_box(32'hfff00000, 32'hfff00000, 32'hfff00000,
                32'h00100000, 32'h00100000, 32'h00100000);
        random_phase(60);
        quiet_tail = 1'b1;
        random_phase(50);

        $display("covered %0d triangles over five box settings, %0d results checked",
                 tris_sent, results_seen);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
